@@ sv/overwrite_byte_fifo_macros.svh @@
// ----------------------------------------------------------------------------
// overwrite_byte_fifo assertion macros
// Shared concurrent check forms for the byte FIFO RTL.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_BYTE_FIFO_MACROS_SVH
`define OVERWRITE_BYTE_FIFO_MACROS_SVH

// same-cycle implication, disabled during reset
`define OFB_CHECK(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define OFB_CHECK_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ sv/ofb_pkg.sv @@
// ----------------------------------------------------------------------------
// ofb_pkg
// Constants, operation codes and shared structs of the overwrite byte FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package ofb_pkg;

	localparam int DEPTH  = 256;              // power of two, 2 .. 256
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 32;               // free-running counter width
	localparam int LVL_W  = 9;                // level fields on the ports
	localparam int PEAK_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 8;

	localparam logic [1:0] OP_WRITE     = 2'd0;
	localparam logic [1:0] OP_OVERWRITE = 2'd1;
	localparam logic [1:0] OP_READ      = 2'd2;
	localparam logic [1:0] OP_RECOVER   = 2'd3;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ofb_mem_req_t;

	typedef struct packed {
		logic             rd_hit;
		logic             accepted;
		logic [LVL_W-1:0] occupancy;
		logic [LVL_W-1:0] free_room;
		logic [LVL_W-1:0] peak_fill;
		logic [CNT_W-1:0] overflow_total;
		logic [CNT_W-1:0] pending_overflow;
		logic [CNT_W-1:0] recovered_count;
	} ofb_result_t;

endpackage

`default_nettype wire

@@ sv/ofb_ram.sv @@
// ----------------------------------------------------------------------------
// ofb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/ofb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ofb_ctrl
// Pointer, level, peak and overflow bookkeeping; one operation per cycle while take is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_ctrl
	import ofb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [1:0]        operation,
	input  wire logic [DATA_W-1:0] write_data,
	output ofb_mem_req_t           mem_req,
	output ofb_result_t            result
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [ADDR_W-1:0] prod_slot_q;
	logic [ADDR_W-1:0] cons_slot_q;
	logic [CNT_W-1:0]  level_q;      // produce minus consume, wrapping
	logic [PEAK_W-1:0] peak_q;
	logic [CNT_W-1:0]  total_q;

	logic              push;
	logic              pop;
	logic              rec;
	logic [CNT_W-1:0]  excess_cur;
	logic [CNT_W-1:0]  level_nx;
	logic [CNT_W-1:0]  sat_nx;
	logic [CNT_W-1:0]  excess_nx;
	logic [CNT_W-1:0]  free_nx;
	logic [CNT_W-1:0]  peak_ext;
	logic [PEAK_W-1:0] peak_nx;
	logic [CNT_W-1:0]  total_nx;
	logic [CNT_W-1:0]  peak_out;

	assign excess_cur = (level_q > DEPTH_C) ? (level_q - DEPTH_C) : '0;

	always_comb begin
		push = 1'b0;
		pop  = 1'b0;
		rec  = 1'b0;
		case (operation)
			OP_WRITE:     push = (level_q < DEPTH_C);
			OP_OVERWRITE: push = 1'b1;
			OP_READ:      pop  = (level_q != '0);
			OP_RECOVER:   rec  = (excess_cur != '0);
			default:      push = 1'b0;
		endcase
	end

	always_comb begin
		if (push) begin
			level_nx = level_q + CNT_W'(1);
		end else if (pop) begin
			level_nx = level_q - CNT_W'(1);
		end else if (rec) begin
			level_nx = DEPTH_C;
		end else begin
			level_nx = level_q;
		end
	end

	assign sat_nx    = (level_nx > DEPTH_C) ? DEPTH_C : level_nx;
	assign excess_nx = (level_nx > DEPTH_C) ? (level_nx - DEPTH_C) : '0;
	assign free_nx   = DEPTH_C - sat_nx;
	assign peak_ext  = CNT_W'(peak_q);
	assign peak_nx   = (push && (sat_nx > peak_ext)) ? PEAK_W'(sat_nx) : peak_q;
	assign total_nx  = rec ? (total_q + excess_cur) : total_q;
	assign peak_out  = CNT_W'(peak_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_slot_q <= '0;
			cons_slot_q <= '0;
			level_q     <= '0;
			peak_q      <= '0;
			total_q     <= '0;
		end else if (take) begin
			if (push) begin
				prod_slot_q <= prod_slot_q + ADDR_W'(1);
			end
			if (pop) begin
				cons_slot_q <= cons_slot_q + ADDR_W'(1);
			end else if (rec) begin
				cons_slot_q <= cons_slot_q + excess_cur[ADDR_W-1:0];
			end
			level_q <= level_nx;
			peak_q  <= peak_nx;
			total_q <= total_nx;
		end
	end

	assign mem_req.we    = take & push;
	assign mem_req.waddr = prod_slot_q;
	assign mem_req.wdata = write_data;
	assign mem_req.re    = take & pop;
	assign mem_req.raddr = cons_slot_q;

	assign result.rd_hit           = pop;
	assign result.accepted         = push | pop | rec;
	assign result.occupancy        = sat_nx[LVL_W-1:0];
	assign result.free_room        = free_nx[LVL_W-1:0];
	assign result.peak_fill        = peak_out[LVL_W-1:0];
	assign result.overflow_total   = total_nx;
	assign result.pending_overflow = excess_nx;
	assign result.recovered_count  = (operation == OP_RECOVER) ? excess_cur : '0;

endmodule

`default_nettype wire

@@ sv/overwrite_byte_fifo.sv @@
// ----------------------------------------------------------------------------
// overwrite_byte_fifo
// Byte FIFO with overwrite and overflow recovery, one operation per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation and a byte:
//   write if space, overwrite write, read, or recover overflow.
//   Output channel (out_valid/out_stall) returns exactly one result per
//   operation: read byte, accepted flag, occupancy, free room, peak
//   fill, overflow total, pending overflow and recovered count.
//   The result of a transaction taken at one edge is valid after that
//   edge. Throughput is one transaction per cycle while the receiver does
//   not stall, set by the single result register and the registered read
//   of the byte store.
//   in_stall is high only while a result waits and the receiver stalls it;
//   the result register and the store read data then hold until taken.
//   Reset clears the counters, level, peak and overflow total and empties
//   the output register; the byte store itself is not cleared and needs no
//   clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "overwrite_byte_fifo_macros.svh"

module overwrite_byte_fifo
	import ofb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [DATA_W-1:0] write_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      read_data,
	output logic                   accepted,
	output logic [LVL_W-1:0]       occupancy,
	output logic [LVL_W-1:0]       free_room,
	output logic [LVL_W-1:0]       peak_fill,
	output logic [CNT_W-1:0]       overflow_total,
	output logic [CNT_W-1:0]       pending_overflow,
	output logic [CNT_W-1:0]       recovered_count
);

	ofb_mem_req_t      mem_req;
	ofb_result_t       result;
	ofb_result_t       res_q;
	logic              out_valid_q;
	logic              take;
	logic [DATA_W-1:0] ram_rdata;

	// Take a transaction unless a finished result is held by the receiver.
	assign in_stall = out_valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	ofb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.operation  (operation),
		.write_data (write_data),
		.mem_req    (mem_req),
		.result     (result)
	);

	// Byte store: written at the produce slot, read at the consume slot.
	// Only one of the two happens per transaction, so no collision.
	ofb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (ram_rdata)
	);

	// Result register. The read byte comes straight from the store's read
	// register, which only moves on an accepted read, so it holds with res_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = res_q.rd_hit ? ram_rdata : '0;
	assign accepted         = res_q.accepted;
	assign occupancy        = res_q.occupancy;
	assign free_room        = res_q.free_room;
	assign peak_fill        = res_q.peak_fill;
	assign overflow_total   = res_q.overflow_total;
	assign pending_overflow = res_q.pending_overflow;
	assign recovered_count  = res_q.recovered_count;

	`OFB_CHECK_NEXT(a_result_follows, clk, arst_n, take, out_valid_q, "no result after transaction")
	`OFB_CHECK(a_stall_needs_result, clk, arst_n, in_stall, out_valid_q, "input stalled with no result")
	`OFB_CHECK(a_level_sum, clk, arst_n, out_valid_q, LVL_W'(occupancy + free_room) == LVL_W'(DEPTH), "level sum off")
	`OFB_CHECK(a_overflow_full, clk, arst_n, out_valid_q && (pending_overflow != '0), occupancy == LVL_W'(DEPTH), "overflow pending while not full")
	`OFB_CHECK(a_recover_flag, clk, arst_n, out_valid_q && (recovered_count != '0), accepted, "recovery not flagged")

endmodule

`default_nettype wire

@@ test/ofb_checker.sv @@
// ----------------------------------------------------------------------------
// ofb_checker
// Watches both channels of the overwrite byte FIFO, predicts each result from
// its own copy of the counters and byte store, and compares every field.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_checker
	import ofb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [DATA_W-1:0] write_data,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [DATA_W-1:0] read_data,
	input  wire logic              accepted,
	input  wire logic [LVL_W-1:0]  occupancy,
	input  wire logic [LVL_W-1:0]  free_room,
	input  wire logic [LVL_W-1:0]  peak_fill,
	input  wire logic [CNT_W-1:0]  overflow_total,
	input  wire logic [CNT_W-1:0]  pending_overflow,
	input  wire logic [CNT_W-1:0]  recovered_count,
	output int                     mismatches,
	output int                     outstanding,
	output int                     checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              accepted;
		logic [LVL_W-1:0]  occupancy;
		logic [LVL_W-1:0]  free_room;
		logic [LVL_W-1:0]  peak_fill;
		logic [CNT_W-1:0]  overflow_total;
		logic [CNT_W-1:0]  pending_overflow;
		logic [CNT_W-1:0]  recovered_count;
	} fifo_result_t;

	logic [DATA_W-1:0] byte_mem [DEPTH];
	logic [CNT_W-1:0]  prod_cnt;
	logic [CNT_W-1:0]  cons_cnt;
	logic [CNT_W-1:0]  peak_lvl;
	logic [CNT_W-1:0]  drop_total;
	fifo_result_t      results_due[$];
	int                err_cnt;
	int                done_cnt;

	function automatic logic [CNT_W-1:0] fill_level();
		logic [CNT_W-1:0] raw;
		raw = prod_cnt - cons_cnt;
		return (raw > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : raw;
	endfunction

	function automatic logic [CNT_W-1:0] excess_level();
		logic [CNT_W-1:0] raw;
		raw = prod_cnt - cons_cnt;
		return (raw > CNT_W'(DEPTH)) ? raw - CNT_W'(DEPTH) : '0;
	endfunction

	function automatic void push_byte(input logic [DATA_W-1:0] b);
		byte_mem[prod_cnt[ADDR_W-1:0]] = b;
		prod_cnt += 1;
		if (fill_level() > peak_lvl) begin
			peak_lvl = fill_level();
		end
	endfunction

	// one operation on the shadow FIFO, returns the result it must produce
	function automatic fifo_result_t step_fifo(input logic [1:0] op,
	                                           input logic [DATA_W-1:0] data);
		fifo_result_t     r;
		logic [CNT_W-1:0] skip;
		logic [CNT_W-1:0] lvl;
		r = '0;
		case (op)
			OP_WRITE: begin
				if (fill_level() < CNT_W'(DEPTH)) begin
					push_byte(data);
					r.accepted = 1'b1;
				end
			end
			OP_OVERWRITE: begin
				push_byte(data);
				r.accepted = 1'b1;
			end
			OP_READ: begin
				if (fill_level() != 0) begin
					r.read_data = byte_mem[cons_cnt[ADDR_W-1:0]];
					cons_cnt += 1;
					r.accepted = 1'b1;
				end
			end
			default: begin
				skip = excess_level();
				if (skip != 0) begin
					cons_cnt   += skip;
					drop_total += skip;
					r.accepted = 1'b1;
				end
				r.recovered_count = skip;
			end
		endcase
		lvl                = fill_level();
		r.occupancy        = lvl[LVL_W-1:0];
		r.free_room        = LVL_W'(CNT_W'(DEPTH) - lvl);
		r.peak_fill        = peak_lvl[LVL_W-1:0];
		r.overflow_total   = drop_total;
		r.pending_overflow = excess_level();
		return r;
	endfunction

	function automatic int field_bad(input string name, input logic [CNT_W-1:0] want,
	                                 input logic [CNT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fifo_result_t want;
		int           bad;
		if (!arst_n) begin
			prod_cnt    = '0;
			cons_cnt    = '0;
			peak_lvl    = '0;
			drop_total  = '0;
			err_cnt     = 0;
			done_cnt    = 0;
			results_due.delete();
			mismatches  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				results_due.push_back(step_fifo(operation, write_data));
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result with no transaction outstanding");
					err_cnt++;
				end else begin
					want = results_due.pop_front();
					bad  = 0;
					bad += field_bad("read_data", CNT_W'(want.read_data), CNT_W'(read_data));
					bad += field_bad("accepted", CNT_W'(want.accepted), CNT_W'(accepted));
					bad += field_bad("occupancy", CNT_W'(want.occupancy), CNT_W'(occupancy));
					bad += field_bad("free_room", CNT_W'(want.free_room),
					                 CNT_W'(free_room));
					bad += field_bad("peak_fill", CNT_W'(want.peak_fill),
					                 CNT_W'(peak_fill));
					bad += field_bad("overflow_total", want.overflow_total, overflow_total);
					bad += field_bad("pending_overflow", want.pending_overflow,
					                 pending_overflow);
					bad += field_bad("recovered_count", want.recovered_count,
					                 recovered_count);
					if (bad != 0) begin
						err_cnt++;
					end
					done_cnt++;
				end
			end
			mismatches  <= err_cnt;
			outstanding <= results_due.size();
			checked     <= done_cnt;
		end
	end

endmodule

`default_nettype wire

@@ test/overwrite_byte_fifo_tb.sv @@
// ----------------------------------------------------------------------------
// overwrite_byte_fifo_tb
// Drives write, overwrite, read and recover transactions into the byte FIFO
// with random idle and stall bursts; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_byte_fifo_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ofb_pkg::*;

	localparam int RANDOM_ITEMS = 1200;  // random transactions after the directed part
	localparam int QUIET_TAIL   = 200;   // last transactions run with no idling

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [DATA_W-1:0] write_data;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] read_data;
	logic              accepted;
	logic [LVL_W-1:0]  occupancy;
	logic [LVL_W-1:0]  free_room;
	logic [LVL_W-1:0]  peak_fill;
	logic [CNT_W-1:0]  overflow_total;
	logic [CNT_W-1:0]  pending_overflow;
	logic [CNT_W-1:0]  recovered_count;

	int   mismatches;
	int   outstanding;
	int   checked;
	logic no_idle;        // set for the tail of the run: no gaps, no stalls
	int   op_count [4];   // transactions sent per operation
	int   send_calm;      // transactions left in a gap-free stretch
	int   stall_left;     // cycles left in a receiver stall burst
	int   stall_calm;     // cycles left in a stall-free stretch

	overwrite_byte_fifo i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.write_data       (write_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.accepted         (accepted),
		.occupancy        (occupancy),
		.free_room        (free_room),
		.peak_fill        (peak_fill),
		.overflow_total   (overflow_total),
		.pending_overflow (pending_overflow),
		.recovered_count  (recovered_count)
	);

	ofb_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.write_data       (write_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.accepted         (accepted),
		.occupancy        (occupancy),
		.free_room        (free_room),
		.peak_fill        (peak_fill),
		.overflow_total   (overflow_total),
		.pending_overflow (pending_overflow),
		.recovered_count  (recovered_count),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.checked          (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: about 2000 transactions finish well under 0.5 ms; allow
	// several times that.
	initial begin
		#4_000_000;
		$display("[overwrite_byte_fifo] ERROR");
		$finish;
	end

	// Receiver side: random stall bursts, broken up by stall-free stretches,
	// and nothing at all once the tail of the run starts.
	always @(posedge clk) begin
		if (!arst_n || no_idle) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			stall_calm <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_calm > 0) begin
			out_stall  <= 1'b0;
			stall_calm <= stall_calm - 1;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					out_stall  <= 1'b1;
					stall_left <= $urandom_range(0, 4);
				end
				3: begin
					out_stall  <= 1'b0;
					stall_calm <= $urandom_range(20, 80);
				end
				default: begin
					out_stall <= 1'b0;
				end
			endcase
		end
	end

	// One transaction: hold valid and payload until the block takes it, then
	// maybe leave a gap with valid low. Valid never looks at stall.
	task automatic send_op(input logic [1:0] op, input logic [DATA_W-1:0] data);
		int gap;
		in_valid   <= 1'b1;
		operation  <= op;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		op_count[op]++;
		if (!no_idle) begin
			if (send_calm > 0) begin
				send_calm--;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: begin
						gap = $urandom_range(1, 5);
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					4: begin
						send_calm = $urandom_range(20, 100);
					end
					default: ;
				endcase
			end
		end
	endtask

	// Hold off the sender until every expected result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Op mix per mode: 0 filling, 1 draining, 2 flooding with overwrites,
	// 3 even mix. Biased runs are what push the level to full and beyond.
	function automatic logic [1:0] choose_op(input int mode);
		int roll;
		roll = $urandom_range(0, 99);
		case (mode)
			0:       return (roll < 50) ? OP_WRITE : (roll < 70) ? OP_OVERWRITE :
			                (roll < 95) ? OP_READ : OP_RECOVER;
			1:       return (roll < 20) ? OP_WRITE : (roll < 25) ? OP_OVERWRITE :
			                (roll < 95) ? OP_READ : OP_RECOVER;
			2:       return (roll < 5) ? OP_WRITE : (roll < 75) ? OP_OVERWRITE :
			                (roll < 90) ? OP_READ : OP_RECOVER;
			default: return roll[1:0];
		endcase
	endfunction

	// Well-formed lap: fill to full, bounce off the full FIFO, overwrite more
	// than a whole lap so pending overflow exceeds the depth, read stale
	// bytes while overflow is pending, recover, then empty it completely.
	task automatic fill_and_flood();
		int extra;
		extra = $urandom_range(3, 20);
		repeat (DEPTH) send_op(OP_WRITE, DATA_W'($urandom_range(0, 255)));
		send_op(OP_WRITE, 8'hFF);                          // write when full
		send_op(OP_WRITE, 8'h00);
		repeat (extra) send_op(OP_OVERWRITE, DATA_W'($urandom_range(0, 255)));
		send_op(OP_READ, 8'h00);                           // read with overflow pending
		send_op(OP_READ, 8'h00);
		repeat (DEPTH + extra) send_op(OP_OVERWRITE, DATA_W'($urandom_range(0, 255)));
		send_op(OP_RECOVER, 8'h00);
		send_op(OP_RECOVER, 8'h00);                        // nothing left to skip
		repeat (DEPTH + 1) send_op(OP_READ, 8'h00);        // last one hits empty
	endtask

	initial begin
		int mode;
		int run_len;
		int sent;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		operation  <= OP_WRITE;
		write_data <= '0;
		no_idle    <= 1'b0;
		op_count   = '{default: 0};
		send_calm  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-FIFO corner cases and data extremes
		send_op(OP_READ, 8'h00);          // read when empty
		send_op(OP_RECOVER, 8'h00);       // recover with nothing pending
		send_op(OP_WRITE, 8'h00);
		send_op(OP_WRITE, 8'hFF);
		send_op(OP_OVERWRITE, 8'hA5);     // overwrite with space behaves like write
		send_op(OP_WRITE, 8'h5A);
		repeat (4) send_op(OP_READ, 8'hFF);
		send_op(OP_READ, 8'h00);          // empty again
		send_op(OP_RECOVER, 8'hFF);
		drain_results();

		fill_and_flood();
		drain_results();

		// random runs of biased op mixes, with a sender hold-off now and then
		// before the tail
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode    = $urandom_range(0, 3);
			run_len = $urandom_range(16, 320);
			for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
				if (sent == RANDOM_ITEMS - QUIET_TAIL) begin
					no_idle <= 1'b1;
				end
				send_op(choose_op(mode), DATA_W'($urandom_range(0, 255)));
				sent++;
			end
			if (!no_idle && ($urandom_range(0, 5) == 0)) begin
				drain_results();
			end
		end

		drain_results();
		repeat (4) @(posedge clk);

		$display("%0d transactions: %0d write, %0d overwrite, %0d read, %0d recover",
		         op_count[OP_WRITE] + op_count[OP_OVERWRITE] + op_count[OP_READ] +
		         op_count[OP_RECOVER], op_count[OP_WRITE], op_count[OP_OVERWRITE],
		         op_count[OP_READ], op_count[OP_RECOVER]);
		$display("%0d results compared, %0d with mismatches", checked, mismatches);
		if (mismatches == 0) begin
			$display("[overwrite_byte_fifo] OK");
		end else begin
			$display("[overwrite_byte_fifo] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/ofb_pkg.sv
sv/ofb_ram.sv
sv/ofb_ctrl.sv
sv/overwrite_byte_fifo.sv
test/ofb_checker.sv
test/overwrite_byte_fifo_tb.sv
